[design/spd_pkg.sv]
// Shared types and constants of the slotted page directory manager.
// Used by the controller, the datapath and the top level; depends on nothing.
package spd_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int MAX_SLOTS_DEF  = 64;
    localparam int HEADER_BYTES   = 16;
    localparam int SLOT_BYTES     = 4;

    localparam int W_REQ    = 3;
    localparam int W_SID    = 16;
    localparam int W_LEN    = 13;
    localparam int W_STATUS = 3;
    localparam int W_RSLOT  = 6;
    localparam int W_FREE   = 12;
    localparam int W_USED   = 7;

    localparam logic [W_REQ-1:0] REQ_FORMAT  = 3'd0;
    localparam logic [W_REQ-1:0] REQ_INSERT  = 3'd1;
    localparam logic [W_REQ-1:0] REQ_GET     = 3'd2;
    localparam logic [W_REQ-1:0] REQ_DELETE  = 3'd3;
    localparam logic [W_REQ-1:0] REQ_COMPACT = 3'd4;

    localparam logic [W_STATUS-1:0] ST_OK       = 3'd0;
    localparam logic [W_STATUS-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [W_STATUS-1:0] ST_BAD_SLOT = 3'd2;
    localparam logic [W_STATUS-1:0] ST_NOTHING  = 3'd3;
    localparam logic [W_STATUS-1:0] ST_DIR_FULL = 3'd4;

    // One command per cycle from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_IDLE       = 4'd0,
        CMD_LOAD       = 4'd1,
        CMD_SCAN       = 4'd2,
        CMD_INS        = 4'd3,
        CMD_CHK        = 4'd4,
        CMD_TRIM_START = 4'd5,
        CMD_TRIM       = 4'd6,
        CMD_CMP        = 4'd7,
        CMD_MOVE       = 4'd8,
        CMD_EMIT       = 4'd9
    } t_cmd;

    typedef struct packed {
        logic sid_ok;
        logic cnt_zero;
        logic len_zero;
        logic at_end;
        logic idx_zero;
        logic tomb;
        logic live_zero;
        logic out_free;
        logic move_last;
        logic is_ins;
        logic is_get;
    } t_dp_status;

endpackage

[design/spd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the slot directory; depends on nothing.
module spd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/spd_ctrl.sv]
// Controller state machine of the slotted page directory manager.
// Depends on spd_pkg for the command code and the datapath status struct.
module spd_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [2:0]              i_req_type,
    input  spd_pkg::t_dp_status     i_st,
    output spd_pkg::t_cmd           o_cmd,
    output logic                    o_in_stall
);
    import spd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_INS   = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_TRIM0 = 9'b000010000,
        S_TRIM  = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_MOVE  = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LOAD;
                    priority if (i_req_type == REQ_INSERT) begin
                        n_state = i_st.cnt_zero ? S_INS : S_SCAN;
                    end else if (i_req_type == REQ_GET || i_req_type == REQ_DELETE) begin
                        n_state = i_st.sid_ok ? S_CHK : S_EMIT;
                    end else if (i_req_type == REQ_COMPACT) begin
                        n_state = i_st.cnt_zero ? S_EMIT : S_SCAN;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                o_cmd = CMD_SCAN;
                if (i_st.is_ins) begin
                    if (i_st.len_zero || i_st.at_end) n_state = S_INS;
                end else if (i_st.at_end) begin
                    n_state = S_CMP;
                end
            end
            S_INS: begin
                o_cmd   = CMD_INS;
                n_state = S_EMIT;
            end
            S_CHK: begin
                o_cmd   = CMD_CHK;
                n_state = (i_st.len_zero || i_st.is_get) ? S_EMIT : S_TRIM0;
            end
            S_TRIM0: begin
                o_cmd   = CMD_TRIM_START;
                n_state = S_TRIM;
            end
            S_TRIM: begin
                o_cmd = CMD_TRIM;
                if (!i_st.len_zero || i_st.idx_zero) n_state = S_EMIT;
            end
            S_CMP: begin
                o_cmd   = CMD_CMP;
                n_state = (!i_st.tomb || i_st.live_zero) ? S_EMIT : S_MOVE;
            end
            S_MOVE: begin
                o_cmd = CMD_MOVE;
                if (!i_st.len_zero && i_st.out_free && i_st.move_last) n_state = S_IDLE;
            end
            S_EMIT: begin
                o_cmd = CMD_EMIT;
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_move_has_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && i_st.tomb && !i_st.live_zero) |=> (r_state == S_MOVE))
        else $error("compaction with live tuples did not enter the move phase");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted word left the controller idle");
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_st.out_free) |=> (r_state == S_EMIT))
        else $error("result dropped while the output register was busy");
`endif
endmodule

[design/spd_dp.sv]
// Datapath: page registers, directory RAM, scan counters and output register.
// Depends on spd_pkg and instantiates spd_ram.
module spd_dp #(
    parameter int PAGE_BYTES = spd_pkg::PAGE_BYTES_DEF,
    parameter int MAX_SLOTS  = spd_pkg::MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spd_pkg::t_cmd         i_cmd,
    input  logic [2:0]            i_req_type,
    input  logic [15:0]           i_slot_id,
    input  logic [12:0]           i_tuple_length,
    input  logic                  i_out_stall,
    output spd_pkg::t_dp_status   o_st,
    output logic                  o_out_valid,
    output logic [2:0]            o_status,
    output logic [5:0]            o_result_slot,
    output logic [12:0]           o_byte_offset,
    output logic [12:0]           o_byte_length,
    output logic [12:0]           o_move_source,
    output logic [11:0]           o_free_bytes,
    output logic [6:0]            o_slots_in_use,
    output logic                  o_last
);
    import spd_pkg::*;

    localparam int PW  = $clog2(PAGE_BYTES + 1);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int XA  = (PW > CW + 3) ? PW : CW + 3;
    localparam int XW  = ((XA > W_LEN) ? XA : W_LEN) + 1;

    logic [PW-1:0]       r_fp;
    logic [CW-1:0]       r_cnt;
    logic [W_REQ-1:0]    r_req;
    logic [W_LEN-1:0]    r_len;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_target;
    logic                r_reuse;
    logic                r_tomb;
    logic [PW-1:0]       r_sum;
    logic [CW-1:0]       r_live;
    logic [PW-1:0]       r_run;
    logic [AW-1:0]       r_dst;
    logic [W_STATUS-1:0] r_res_status;
    logic [AW-1:0]       r_res_slot;
    logic [PW-1:0]       r_res_off;
    logic [PW-1:0]       r_res_len;

    logic                r_ov;
    logic [W_STATUS-1:0] r_o_status;
    logic [W_RSLOT-1:0]  r_o_slot;
    logic [W_LEN-1:0]    r_o_off;
    logic [W_LEN-1:0]    r_o_len;
    logic [W_LEN-1:0]    r_o_src;
    logic [W_FREE-1:0]   r_o_free;
    logic [W_USED-1:0]   r_o_used;
    logic                r_o_last;

    logic [2*PW-1:0] rd_data, wr_data;
    logic [PW-1:0]   rd_len, rd_off;
    logic [AW-1:0]   raddr, waddr;
    logic            we;

    logic [XW-1:0]   used_x, free_x, need_x;
    logic            len_zero, at_end, idx_zero, out_free, move_last, sid_ok;
    logic            full, no_space, get_del_in, scan_adv, move_adv;
    logic [PW-1:0]   fp_new, run_new;

    assign rd_len = rd_data[PW-1:0];
    assign rd_off = rd_data[2*PW-1:PW];

    assign used_x = XW'(HEADER_BYTES) + (XW'(r_cnt) << 2);
    assign free_x = (used_x > XW'(r_fp)) ? '0 : XW'(r_fp) - used_x;
    assign need_x = XW'(r_len) + (r_reuse ? XW'(0) : XW'(SLOT_BYTES));
    assign full     = !r_reuse && (r_cnt >= CW'(MAX_SLOTS));
    assign no_space = free_x < need_x;
    assign fp_new   = PW'(XW'(r_fp) - XW'(r_len));
    assign run_new  = r_run - rd_len;

    assign len_zero  = (rd_len == '0);
    assign at_end    = (CW'(r_idx) + CW'(1)) == r_cnt;
    assign idx_zero  = (r_idx == '0);
    assign out_free  = !r_ov || !i_out_stall;
    assign move_last = (CW'(r_dst) + CW'(1)) == r_cnt;
    assign sid_ok    = i_slot_id < W_SID'(r_cnt);
    assign get_del_in = (i_req_type == REQ_GET) || (i_req_type == REQ_DELETE);
    assign scan_adv  = (r_req == REQ_INSERT) ? !(len_zero || at_end) : !at_end;
    assign move_adv  = len_zero || out_free;

    assign o_st.sid_ok    = sid_ok;
    assign o_st.cnt_zero  = (r_cnt == '0);
    assign o_st.len_zero  = len_zero;
    assign o_st.at_end    = at_end;
    assign o_st.idx_zero  = idx_zero;
    assign o_st.tomb      = r_tomb;
    assign o_st.live_zero = (r_live == '0);
    assign o_st.out_free  = out_free;
    assign o_st.move_last = move_last;
    assign o_st.is_ins    = (r_req == REQ_INSERT);
    assign o_st.is_get    = (r_req == REQ_GET);

    // Read address: outside CMD_IDLE, the RAM output next holds the entry at r_idx.
    always_comb begin
        unique case (i_cmd)
            CMD_IDLE, CMD_LOAD: raddr = get_del_in ? i_slot_id[AW-1:0] : '0;
            CMD_SCAN:           raddr = scan_adv ? r_idx + AW'(1) : r_idx;
            CMD_TRIM_START:     raddr = AW'(r_cnt - CW'(1));
            CMD_TRIM:           raddr = (len_zero && !idx_zero) ? r_idx - AW'(1) : r_idx;
            CMD_CMP:            raddr = '0;
            CMD_MOVE:           raddr = move_adv ? r_idx + AW'(1) : r_idx;
            default:            raddr = r_idx;
        endcase
    end

    always_comb begin
        we      = 1'b0;
        waddr   = r_idx;
        wr_data = {rd_off, {PW{1'b0}}};
        unique case (i_cmd)
            CMD_INS: begin
                we      = !full && !no_space;
                waddr   = r_target;
                wr_data = {fp_new, PW'(r_len)};
            end
            CMD_CHK: begin
                we = !len_zero && (r_req == REQ_DELETE);
            end
            CMD_MOVE: begin
                we      = !len_zero && out_free;
                waddr   = r_dst;
                wr_data = {run_new, rd_len};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    spd_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_SLOTS)
    ) u_dir (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Page state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp  <= PW'(PAGE_BYTES);
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (!i_out_stall) r_ov <= 1'b0;
            unique case (i_cmd)
                CMD_LOAD: begin
                    if (i_req_type == REQ_FORMAT) begin
                        r_fp  <= PW'(PAGE_BYTES);
                        r_cnt <= '0;
                    end
                end
                CMD_INS: begin
                    if (!full && !no_space) begin
                        r_fp <= fp_new;
                        if (!r_reuse) r_cnt <= r_cnt + CW'(1);
                    end
                end
                CMD_TRIM: begin
                    if (len_zero) r_cnt <= CW'(r_idx);
                end
                CMD_CMP: begin
                    if (r_tomb) begin
                        r_fp  <= PW'(PAGE_BYTES) - r_sum;
                        r_cnt <= r_live;
                    end
                end
                CMD_MOVE: begin
                    if (!len_zero && out_free) r_ov <= 1'b1;
                end
                CMD_EMIT: begin
                    if (out_free) r_ov <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and result fields.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_req        <= i_req_type;
                r_len        <= i_tuple_length;
                r_idx        <= get_del_in ? i_slot_id[AW-1:0] : '0;
                r_target     <= AW'(r_cnt);
                r_reuse      <= 1'b0;
                r_tomb       <= 1'b0;
                r_sum        <= '0;
                r_live       <= '0;
                r_res_slot   <= '0;
                r_res_off    <= '0;
                r_res_len    <= '0;
                r_res_status <= ST_OK;
                if (get_del_in && !sid_ok) r_res_status <= ST_BAD_SLOT;
                if (i_req_type == REQ_COMPACT && r_cnt == '0) r_res_status <= ST_NOTHING;
            end
            CMD_SCAN: begin
                if (r_req == REQ_INSERT) begin
                    if (len_zero) begin
                        r_reuse  <= 1'b1;
                        r_target <= r_idx;
                    end
                end else if (len_zero) begin
                    r_tomb <= 1'b1;
                end else begin
                    r_sum  <= r_sum + rd_len;
                    r_live <= r_live + CW'(1);
                end
                if (scan_adv) r_idx <= r_idx + AW'(1);
            end
            CMD_INS: begin
                priority if (full) begin
                    r_res_status <= ST_DIR_FULL;
                end else if (no_space) begin
                    r_res_status <= ST_NO_SPACE;
                end else begin
                    r_res_slot <= r_target;
                    r_res_off  <= fp_new;
                end
            end
            CMD_CHK: begin
                if (len_zero) begin
                    r_res_status <= ST_BAD_SLOT;
                end else if (r_req == REQ_GET) begin
                    r_res_off <= rd_off;
                    r_res_len <= rd_len;
                end
            end
            CMD_TRIM_START: begin
                r_idx <= AW'(r_cnt - CW'(1));
            end
            CMD_TRIM: begin
                if (len_zero && !idx_zero) r_idx <= r_idx - AW'(1);
            end
            CMD_CMP: begin
                if (!r_tomb) r_res_status <= ST_NOTHING;
                r_run <= PW'(PAGE_BYTES);
                r_dst <= '0;
                r_idx <= '0;
            end
            CMD_MOVE: begin
                if (move_adv) r_idx <= r_idx + AW'(1);
                if (!len_zero && out_free) begin
                    r_run <= run_new;
                    r_dst <= r_dst + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_EMIT && out_free) begin
            r_o_status <= r_res_status;
            r_o_slot   <= W_RSLOT'(r_res_slot);
            r_o_off    <= W_LEN'(r_res_off);
            r_o_len    <= W_LEN'(r_res_len);
            r_o_src    <= '0;
            r_o_free   <= free_x[W_FREE-1:0];
            r_o_used   <= W_USED'(r_cnt);
            r_o_last   <= 1'b1;
        end else if (i_cmd == CMD_MOVE && !len_zero && out_free) begin
            r_o_status <= ST_OK;
            r_o_slot   <= W_RSLOT'(r_dst);
            r_o_off    <= W_LEN'(run_new);
            r_o_len    <= W_LEN'(rd_len);
            r_o_src    <= W_LEN'(rd_off);
            r_o_free   <= free_x[W_FREE-1:0];
            r_o_used   <= W_USED'(r_cnt);
            r_o_last   <= move_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_result_slot  = r_o_slot;
    assign o_byte_offset  = r_o_off;
    assign o_byte_length  = r_o_len;
    assign o_move_source  = r_o_src;
    assign o_free_bytes   = r_o_free;
    assign o_slots_in_use = r_o_used;
    assign o_last         = r_o_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SLOTS))
        else $error("slot count above directory size");
    a_fp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fp <= PW'(PAGE_BYTES))
        else $error("free pointer beyond page end");
    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && i_cmd == CMD_MOVE) |-> (r_dst <= r_idx))
        else $error("compaction write overtook its read");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_IDLE || i_cmd == CMD_LOAD) |-> !we)
        else $error("directory written while idle");
`endif
endmodule

[design/slotted_page_directory_manager_top.sv]
// Top level of the slotted page directory manager.
// Depends on spd_pkg; instantiates spd_ctrl and spd_dp (which holds spd_ram).

// The block keeps the slot directory (offset and length per slot), the free
// pointer and the slot count of one database page and answers one request
// word at a time: format, insert, get, delete and compact. Every request gives
// one result word except a compaction that finds a tombstone and live tuples,
// which gives one move word per live tuple in old slot order; o_last marks the
// final word of a request. Insert scans the directory for a tombstone, delete
// trims trailing tombstones, and compact makes one summing pass and then one
// move pass. The directory RAM has one read port, and the controller walks it
// one entry per cycle while the output side does not stall. A new request
// word is taken only when the previous one has finished; a finished result may
// still wait in the output register while the next request is accepted.
module slotted_page_directory_manager_top #(
    parameter int PAGE_BYTES = spd_pkg::PAGE_BYTES_DEF,
    parameter int MAX_SLOTS  = spd_pkg::MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_slot_id,
    input  logic [12:0] i_tuple_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_result_slot,
    output logic [12:0] o_byte_offset,
    output logic [12:0] o_byte_length,
    output logic [12:0] o_move_source,
    output logic [11:0] o_free_bytes,
    output logic [6:0]  o_slots_in_use,
    output logic        o_last
);
    import spd_pkg::*;

    // Command from the controller and status back from the datapath.
    t_cmd       cmd;
    t_dp_status dp_st;

    spd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_st       (dp_st),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    spd_dp #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_slot_id      (i_slot_id),
        .i_tuple_length (i_tuple_length),
        .i_out_stall    (i_out_stall),
        .o_st           (dp_st),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_byte_offset  (o_byte_offset),
        .o_byte_length  (o_byte_length),
        .o_move_source  (o_move_source),
        .o_free_bytes   (o_free_bytes),
        .o_slots_in_use (o_slots_in_use),
        .o_last         (o_last)
    );
endmodule

[tb/slotted_page_directory_manager_top_test.sv]
// Testbench for the slotted page directory manager: directed and random requests
// are checked word by word against an in-bench model of the page directory.
// Depends on spd_pkg and slotted_page_directory_manager_top.
`timescale 1ns / 100ps

module slotted_page_directory_manager_top_test;
    import spd_pkg::*;

    localparam int PAGE = PAGE_BYTES_DEF;
    localparam int NSLOT = MAX_SLOTS_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  rslot;
        logic [12:0] offset;
        logic [12:0] length;
        logic [12:0] source;
        logic [11:0] free;
        logic [6:0]  used;
        logic        last;
    } t_page_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [15:0] i_slot_id;
    logic [12:0] i_tuple_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [5:0]  o_result_slot;
    logic [12:0] o_byte_offset;
    logic [12:0] o_byte_length;
    logic [12:0] o_move_source;
    logic [11:0] o_free_bytes;
    logic [6:0]  o_slots_in_use;
    logic        o_last;

    slotted_page_directory_manager_top i_dut (.*);

    // Shadow copy of the directory the block should be holding.
    int unsigned dir_off[NSLOT];
    int unsigned dir_len[NSLOT];
    int unsigned free_ptr;
    int unsigned slot_cnt;

    t_page_word expected_words[$];
    t_page_word pending[$];
    int  error_count;
    bit  calm;   // when set, neither side idles

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int unsigned page_free();
        int unsigned used;
        used = HEADER_BYTES + slot_cnt * SLOT_BYTES;
        return (used > free_ptr) ? 0 : free_ptr - used;
    endfunction

    function automatic void push_word(logic [2:0] st, int unsigned slot, int unsigned off,
                                      int unsigned len, int unsigned src);
        t_page_word w;
        w = '0;
        w.status = st;
        w.rslot  = slot[5:0];
        w.offset = off[12:0];
        w.length = len[12:0];
        w.source = src[12:0];
        pending = {pending, w};
    endfunction

    // Free bytes, count and last flag describe the page after the whole request.
    function automatic void close_request();
        int unsigned n;
        n = pending.size();
        for (int k = 0; k < n; k++) begin
            t_page_word w;
            w = pending.pop_front();
            w.free = page_free();
            w.used = slot_cnt[6:0];
            w.last = (k == n - 1);
            expected_words = {expected_words, w};
        end
    endfunction

    function automatic void predict_request(logic [2:0] req, logic [15:0] sid,
                                            logic [12:0] len);
        int unsigned target;
        int unsigned need;
        int unsigned old_cnt;
        int unsigned dst;
        bit reuse;
        bit tomb;
        reuse = 0;
        tomb = 0;
        case (req)
            REQ_FORMAT: begin
                free_ptr = PAGE;
                slot_cnt = 0;
                push_word(ST_OK, 0, 0, 0, 0);
            end
            REQ_INSERT: begin
                target = slot_cnt;
                need = len;
                for (int i = 0; i < slot_cnt; i++) begin
                    if (dir_len[i] == 0) begin
                        target = i;
                        reuse = 1;
                        break;
                    end
                end
                if (!reuse && slot_cnt >= NSLOT) begin
                    push_word(ST_DIR_FULL, 0, 0, 0, 0);
                end else begin
                    if (!reuse) need += SLOT_BYTES;
                    if (page_free() < need) begin
                        push_word(ST_NO_SPACE, 0, 0, 0, 0);
                    end else begin
                        free_ptr -= len;
                        dir_off[target] = free_ptr;
                        dir_len[target] = len;
                        if (!reuse) slot_cnt++;
                        push_word(ST_OK, target, free_ptr, 0, 0);
                    end
                end
            end
            REQ_GET, REQ_DELETE: begin
                if (sid >= slot_cnt || dir_len[sid] == 0) begin
                    push_word(ST_BAD_SLOT, 0, 0, 0, 0);
                end else if (req == REQ_GET) begin
                    push_word(ST_OK, 0, dir_off[sid], dir_len[sid], 0);
                end else begin
                    dir_len[sid] = 0;
                    while (slot_cnt > 0 && dir_len[slot_cnt - 1] == 0) slot_cnt--;
                    push_word(ST_OK, 0, 0, 0, 0);
                end
            end
            REQ_COMPACT: begin
                old_cnt = slot_cnt;
                for (int i = 0; i < old_cnt; i++) begin
                    if (dir_len[i] == 0) tomb = 1;
                end
                if (!tomb) begin
                    push_word(ST_NOTHING, 0, 0, 0, 0);
                end else begin
                    free_ptr = PAGE;
                    dst = 0;
                    for (int i = 0; i < old_cnt; i++) begin
                        int unsigned l;
                        int unsigned s;
                        l = dir_len[i];
                        s = dir_off[i];
                        if (l != 0) begin
                            free_ptr -= l;
                            dir_off[dst] = free_ptr;
                            dir_len[dst] = l;
                            push_word(ST_OK, dst, free_ptr, l, s);
                            dst++;
                        end
                    end
                    slot_cnt = dst;
                    if (dst == 0) push_word(ST_OK, 0, 0, 0, 0);
                end
            end
            default: push_word(ST_OK, 0, 0, 0, 0);
        endcase
        close_request();
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    // Sends one request word; the prediction is made when it is accepted.
    // Valid is dropped only while idling, so back-to-back words keep it high.
    task automatic send_request(logic [2:0] req, logic [15:0] sid, logic [12:0] len);
        while (idle_now()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_slot_id      <= sid;
        i_tuple_length <= len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(req, sid, len);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    // Output side: random stall, checked at the rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) i_out_stall <= idle_now();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_page_word got;
            t_page_word exp_w;
            got = {o_status, o_result_slot, o_byte_offset, o_byte_length, o_move_source,
                   o_free_bytes, o_slots_in_use, o_last};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w) begin
                    $display({"%0t: mismatch expected st=%0d slot=%0d off=%0d len=%0d ",
                              "src=%0d free=%0d used=%0d last=%0d"},
                             $time, exp_w.status, exp_w.rslot, exp_w.offset, exp_w.length,
                             exp_w.source, exp_w.free, exp_w.used, exp_w.last);
                    $display({"%0t:          actual   st=%0d slot=%0d off=%0d len=%0d ",
                              "src=%0d free=%0d used=%0d last=%0d"},
                             $time, got.status, got.rslot, got.offset, got.length,
                             got.source, got.free, got.used, got.last);
                    error_count++;
                end
            end
        end
    end

    // Format, every request code, bad slots, zero-length insert and empty pages.
    task automatic test_directed();
        send_request(REQ_FORMAT, 16'd0, 13'd0);
        send_request(REQ_COMPACT, 16'd0, 13'd0);
        send_request(REQ_GET, 16'd0, 13'd0);
        send_request(REQ_DELETE, 16'hFFFF, 13'd0);
        send_request(REQ_INSERT, 16'hFFFF, 13'd0);
        send_request(REQ_INSERT, 16'd0, 13'd100);
        send_request(REQ_INSERT, 16'd0, 13'd200);
        send_request(REQ_GET, 16'd0, 13'h1FFF);
        send_request(REQ_GET, 16'd1, 13'd0);
        send_request(REQ_GET, 16'd2, 13'd0);
        send_request(REQ_COMPACT, 16'd0, 13'd0);
        send_request(REQ_DELETE, 16'd1, 13'd0);
        send_request(REQ_INSERT, 16'd0, 13'd4096);
        send_request(REQ_INSERT, 16'd0, 13'h1FFF);
        send_request(3'd5, 16'hAAAA, 13'h0AAA);
        send_request(3'd7, 16'h5555, 13'h1555);
        send_request(REQ_COMPACT, 16'd0, 13'd0);
        send_request(REQ_DELETE, 16'd1, 13'd0);
        send_request(REQ_DELETE, 16'd1, 13'd0);
        send_request(REQ_COMPACT, 16'd0, 13'd0);
        send_request(REQ_INSERT, 16'd0, 13'd3968);
        send_request(REQ_GET, 16'd3, 13'd0);
        send_request(REQ_FORMAT, 16'd0, 13'd0);
        send_request(3'd6, 16'd0, 13'd0);
    endtask

    // Fill toward full with NSLOT + 2 small inserts, then delete, insert and compact.
    task automatic test_directory_full();
        send_request(REQ_FORMAT, 16'd0, 13'd0);
        for (int i = 0; i < NSLOT + 2; i++)
            send_request(REQ_INSERT, 16'($urandom), 13'($urandom_range(3)));
        for (int i = 0; i < 8; i++)
            send_request(REQ_DELETE, 16'($urandom_range(NSLOT - 1)), 13'd0);
        send_request(REQ_INSERT, 16'd0, 13'd5);
        send_request(REQ_COMPACT, 16'd0, 13'd0);
    endtask

    // Mostly well-formed traffic on live slots, with some noise.
    task automatic test_random(int count, bit quiet);
        calm = quiet;
        for (int n = 0; n < count; n++) begin
            int unsigned pick;
            logic [15:0] sid;
            logic [12:0] len;
            pick = $urandom_range(99);
            sid = (slot_cnt != 0 && $urandom_range(9) != 0) ?
                  16'($urandom_range(slot_cnt - 1)) : 16'($urandom);
            len = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(120));
            if (pick < 40)      send_request(REQ_INSERT, 16'($urandom), len);
            else if (pick < 62) send_request(REQ_GET, sid, 13'($urandom));
            else if (pick < 86) send_request(REQ_DELETE, sid, 13'($urandom));
            else if (pick < 95) send_request(REQ_COMPACT, 16'($urandom), 13'($urandom));
            else if (pick < 97) send_request(REQ_FORMAT, 16'($urandom), 13'($urandom));
            else                send_request(3'($urandom_range(7, 5)), 16'($urandom),
                                             13'($urandom));
        end
        calm = 0;
    endtask

    initial begin
        error_count    = 0;
        calm           = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = '0;
        i_slot_id      = '0;
        i_tuple_length = '0;
        i_out_stall    = 1'b0;
        free_ptr       = PAGE;
        slot_cnt       = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_directory_full();
        test_random(280, 0);
        test_random(60, 1);
        test_random(0 + 20, 0);
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("slotted_page_directory_manager_top_test passed");
        end else begin
            $display("slotted_page_directory_manager_top_test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("slotted_page_directory_manager_top_test failed");
        $finish;
    end

endmodule
